/* rtl/rud_pkg.sv */
`default_nettype none
package rud_pkg;

  // Operand width of the divider; the stream fields stay at FIELD_W bits.
  localparam int DATA_WIDTH = 64;
  localparam int FIELD_W    = 64;

  // Word carried from one cell to the next.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] rem;  // partial remainder
    logic [DATA_WIDTH-1:0] num;  // dividend bits not yet taken in, MSB first
    logic [DATA_WIDTH-1:0] den;  // divisor
    logic [DATA_WIDTH-1:0] quo;  // quotient bits found so far
  } stage_t;

endpackage
`default_nettype wire

/* rtl/rud_cell.sv */
`default_nettype none
module rud_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire rud_pkg::stage_t in_stage,
  output logic                 out_valid,
  output rud_pkg::stage_t      out_stage
);
  import rud_pkg::*;

  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH+1:0] diff;
  logic                  take;
  stage_t                stage_next;

  // Shift in the next dividend bit; subtract when no borrow comes out.
  always_comb begin
    shifted    = {in_stage.rem, in_stage.num[DATA_WIDTH-1]};
    diff       = {1'b0, shifted} - {2'b00, in_stage.den};
    take       = ~diff[DATA_WIDTH+1];
    stage_next.rem = take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
    stage_next.num = {in_stage.num[DATA_WIDTH-2:0], 1'b0};
    stage_next.den = in_stage.den;
    stage_next.quo = {in_stage.quo[DATA_WIDTH-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/restoring_unsigned_divider.sv */
`default_nettype none
// Channel   Direction  Handshake          Payload
// s_axis    in         tvalid / tready    tdata[127:0] = {divisor, dividend}
// m_axis    out        tvalid / tready    tdata[63:0]  = quotient
//
// Each request passes one cell per quotient bit (DATA_WIDTH cells), then the
// output register. One request enters per cycle while the skid is empty.
// Reset (synchronous, active high) clears every valid bit; payload is not reset.
// A stalled output fills a one-entry skid register; only then does the cell
// chain freeze and s_axis_tready drop, so tready depends on a register only.
module restoring_unsigned_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [63:0] dividend, [127:64] divisor
  input  wire logic [2*rud_pkg::FIELD_W-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [63:0] quotient
  output logic [rud_pkg::FIELD_W-1:0]        m_axis_tdata
);
  import rud_pkg::*;

  stage_t                chain       [0:DATA_WIDTH];
  logic                  chain_valid [0:DATA_WIDTH];
  logic                  en;
  logic                  skid_valid;
  logic [DATA_WIDTH-1:0] skid_q;
  logic [DATA_WIDTH-1:0] out_q;

  // Advance the whole chain unless the skid register is occupied.
  assign en            = ~skid_valid;
  assign s_axis_tready = en;

  // Head of the chain: start with an empty remainder and no quotient bits.
  always_comb begin
    chain_valid[0] = s_axis_tvalid;
    chain[0].rem   = '0;
    chain[0].num   = s_axis_tdata[DATA_WIDTH-1:0];
    chain[0].den   = s_axis_tdata[FIELD_W +: DATA_WIDTH];
    chain[0].quo   = '0;
  end

  // One cell per quotient bit, most significant bit first.
  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_cell
    rud_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[k]),
      .in_stage  (chain[k]),
      .out_valid (chain_valid[k+1]),
      .out_stage (chain[k+1])
    );
  end

  // Output register with skid: drain the skid first, else take the chain tail.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (m_axis_tready || !m_axis_tvalid) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= chain_valid[DATA_WIDTH];
      end
    end else if (chain_valid[DATA_WIDTH]) begin
      // Output holds; mark the skid full (skid_q loads only while en is high).
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !m_axis_tvalid) begin
      out_q <= skid_valid ? skid_q : chain[DATA_WIDTH].quo;
    end else if (en) begin
      skid_q <= chain[DATA_WIDTH].quo;
    end
  end

  // Zero-extend the quotient to the field width.
  assign m_axis_tdata = FIELD_W'(out_q);

endmodule
`default_nettype wire
